@@ hdl/tcd_pkg.sv @@
// Shared types and constants for the trilinear charge deposition core.
// Has no dependencies; the front, queue, back and top files import it.
`timescale 1ns / 1ps
package tcd_pkg;

  localparam int unsigned MAX_FRAC_BITS = 24;
  localparam int unsigned MAX_IDX_BITS  = 8;

  typedef enum logic [1:0] {
    CMD_DEPOSIT  = 2'd0,
    CMD_READ     = 2'd1,
    CMD_READ_CLR = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_e;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_INV_X    = 3'd3;
  localparam logic [2:0] REG_INV_Y    = 3'd4;
  localparam logic [2:0] REG_INV_Z    = 3'd5;

  typedef struct packed {
    logic [2:0][31:0] origin;
    logic [2:0][31:0] inv_cell;
  } cfg_t;

  typedef struct packed {
    cmd_e                             cmd;
    logic signed [31:0]               charge;
    logic [2:0][MAX_FRAC_BITS-1:0]    hi_wgt;
    logic [2:0][MAX_IDX_BITS-1:0]     base;
    logic [2:0]                       lo_ok;
    logic [2:0]                       hi_ok;
    logic [2:0][3:0]                  rd_idx;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_AXIS,
    FR_PUSH
  } fr_state_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RD_WAIT,
    BK_W1,
    BK_W2,
    BK_Q,
    BK_WR,
    BK_DONE
  } bk_state_e;

endpackage

@@ hdl/tcd_if.sv @@
// Valid/ready channel interfaces for the deposit core's input and result beats.
// Depends on nothing.
`timescale 1ns / 1ps
interface tcd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] charge;
  logic [3:0]  cell_x;
  logic [3:0]  cell_y;
  logic [3:0]  cell_z;

  modport source (output valid, command, pos_x, pos_y, pos_z, charge, cell_x, cell_y, cell_z,
                  input ready);
  modport sink (input valid, command, pos_x, pos_y, pos_z, charge, cell_x, cell_y, cell_z,
                output ready);
endinterface

interface tcd_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] cell_value;
  logic        out_of_range;
  logic        saturated;

  modport source (output valid, cell_value, out_of_range, saturated, input ready);
  modport sink (input valid, cell_value, out_of_range, saturated, output ready);
endinterface

@@ hdl/tcd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module tcd_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ hdl/tcd_front.sv @@
// Front end: accepts beats, computes per-axis base cell and weights with one shared multiplier.
// Depends on tcd_pkg and tcd_if.
`timescale 1ns / 1ps
module tcd_front #(
  parameter int unsigned GRID_DIM  = 16,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tcd_pkg::cfg_t cfg_i,
  input  logic          clear_busy_i,
  input  logic          full_i,
  output logic          push_o,
  output tcd_pkg::entry_t entry_o,
  tcd_in_if.sink        in_if
);
  import tcd_pkg::*;

  localparam int unsigned PW = 66;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] GMAX = PW'(GRID_DIM);
  localparam logic signed [PW-1:0] GMAX_M1 = PW'(GRID_DIM - 1);
  localparam logic signed [PW-1:0] MINUS1 = '1;

  fr_state_e state_q, state_d;
  logic [1:0] ax_q, ax_d;
  logic [1:0] post_ax;
  entry_t entry_q;
  logic [2:0][31:0] pos_q;
  logic signed [PW-1:0] prod_q;
  logic signed [32:0] mul_a, mul_b;
  logic signed [PW-1:0] lval, bval;
  logic accept;

  always_comb begin
    state_d = state_q;
    ax_d = ax_q;
    unique case (state_q)
      FR_IDLE: begin
        if (accept) begin
          ax_d = 2'd0;
          state_d = (cmd_e'(in_if.command) == CMD_DEPOSIT) ? FR_AXIS : FR_PUSH;
        end
      end
      FR_AXIS: begin
        ax_d = ax_q + 2'd1;
        if (ax_q == 2'd3) begin
          state_d = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!full_i) begin
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready = 1'b0;
    push_o = 1'b0;
    unique case (state_q)
      FR_IDLE: in_if.ready = !clear_busy_i;
      FR_PUSH: push_o = !full_i;
      default: ;
    endcase
  end

  assign accept = in_if.valid && in_if.ready;
  assign post_ax = ax_q - 2'd1;

  always_comb begin
    mul_a = {pos_q[ax_q][31], pos_q[ax_q]} - {cfg_i.origin[ax_q][31], cfg_i.origin[ax_q]};
    mul_b = {1'b0, cfg_i.inv_cell[ax_q]};
    if (ax_q == 2'd3) begin
      mul_a = '0;
      mul_b = '0;
    end
    lval = (prod_q >>> FRAC_BITS) - HALF;
    bval = lval >>> FRAC_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      ax_q <= 2'd0;
    end else begin
      state_q <= state_d;
      ax_q <= ax_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q.cmd <= cmd_e'(in_if.command);
      entry_q.charge <= $signed(in_if.charge);
      entry_q.rd_idx <= {in_if.cell_z, in_if.cell_y, in_if.cell_x};
      entry_q.lo_ok <= '0;
      entry_q.hi_ok <= '0;
      pos_q <= {in_if.pos_z, in_if.pos_y, in_if.pos_x};
    end
    if (state_q == FR_AXIS) begin
      prod_q <= mul_a * mul_b;
      if (ax_q != 2'd0) begin
        entry_q.hi_wgt[post_ax] <= MAX_FRAC_BITS'(lval[FRAC_BITS-1:0]);
        entry_q.base[post_ax] <= bval[MAX_IDX_BITS-1:0];
        entry_q.lo_ok[post_ax] <= (bval >= 0) && (bval < GMAX);
        entry_q.hi_ok[post_ax] <= (bval >= MINUS1) && (bval < GMAX_M1);
      end
    end
  end

  assign entry_o = entry_q;
endmodule

@@ hdl/tcd_fifo.sv @@
// Short queue of classified work items between the front and back ends.
// Depends on tcd_pkg.
`timescale 1ns / 1ps
module tcd_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tcd_pkg::q_ctrl_t ctrl_i,
  input  tcd_pkg::entry_t  data_i,
  output tcd_pkg::entry_t  data_o,
  output logic             full_o,
  output logic             empty_o
);
  import tcd_pkg::*;

  localparam int unsigned PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  entry_t mem_q [DEPTH];
  logic [PTRW-1:0] wptr_q, rptr_q;
  logic [CNTW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = ctrl_i.push && !full_o;
  assign do_pop  = ctrl_i.pop && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PTRW'(DEPTH - 1)) ? '0 : wptr_q + PTRW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PTRW'(DEPTH - 1)) ? '0 : rptr_q + PTRW'(1);
      end
      cnt_q <= cnt_q + CNTW'(do_push) - CNTW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end
endmodule

@@ hdl/tcd_back.sv @@
// Back end: clears the grid after reset and runs reads and per-corner read-modify-write deposits.
// Depends on tcd_pkg, tcd_if and tcd_ram.
`timescale 1ns / 1ps
module tcd_back #(
  parameter int unsigned GRID_DIM  = 16,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tcd_pkg::entry_t ent_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            clear_busy_o,
  tcd_out_if.source       out_if
);
  import tcd_pkg::*;

  localparam int unsigned CELLS = GRID_DIM * GRID_DIM * GRID_DIM;
  localparam int unsigned AW = $clog2(CELLS);
  localparam int unsigned IW = $clog2(GRID_DIM);
  localparam int unsigned WW = FRAC_BITS + 1;
  localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

  bk_state_e state_q, state_d;
  logic [AW-1:0] clr_q;
  logic [2:0] c_q;
  logic [WW-1:0] w1_q, w2_q;
  logic signed [33:0] add_q;
  logic [47:0] val_q;
  logic oor_q, sat_q;
  logic out_valid_q;
  logic [47:0] out_val_q;
  logic out_oor_q, out_sat_q;

  logic [2:0][IW-1:0] crd;
  logic [2:0][WW-1:0] wgt;
  logic [2:0] ok;
  logic [AW-1:0] dep_addr, rd_addr;
  logic rd_in_range;
  logic [2*WW-1:0] p1, p2;
  logic signed [FRAC_BITS+33:0] p3;
  logic signed [48:0] sum;
  logic [47:0] sum_sat;
  logic sum_ovf;
  logic slot_free;
  logic ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [47:0] ram_wdata, ram_rdata;

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] x, input logic [IW-1:0] y,
                                              input logic [IW-1:0] z);
    cell_addr = AW'(x) + AW'(GRID_DIM) * AW'(y) + AW'(GRID_DIM * GRID_DIM) * AW'(z);
  endfunction

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      crd[a] = IW'(ent_i.base[a]) + IW'(c_q[a]);
      ok[a]  = c_q[a] ? ent_i.hi_ok[a] : ent_i.lo_ok[a];
      wgt[a] = c_q[a] ? WW'(ent_i.hi_wgt[a][FRAC_BITS-1:0])
                      : ONE - WW'(ent_i.hi_wgt[a][FRAC_BITS-1:0]);
    end
    dep_addr = cell_addr(crd[0], crd[1], crd[2]);
    rd_addr = cell_addr(IW'(ent_i.rd_idx[0]), IW'(ent_i.rd_idx[1]), IW'(ent_i.rd_idx[2]));
    rd_in_range = (9'(ent_i.rd_idx[0]) < 9'(GRID_DIM)) && (9'(ent_i.rd_idx[1]) < 9'(GRID_DIM))
               && (9'(ent_i.rd_idx[2]) < 9'(GRID_DIM));
    p1 = wgt[0] * wgt[1];
    p2 = w1_q * wgt[2];
    p3 = ent_i.charge * $signed({1'b0, w2_q});
    sum = {ram_rdata[47], ram_rdata} + 49'(add_q);
    sum_ovf = (sum[48] != sum[47]);
    sum_sat = sum_ovf ? {sum[48], {47{~sum[48]}}} : sum[47:0];
  end

  assign slot_free = !out_valid_q || out_if.ready;
  assign clear_busy_o = (state_q == BK_CLEAR);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_CLEAR: if (clr_q == AW'(CELLS - 1)) state_d = BK_IDLE;
      BK_IDLE: begin
        if (!empty_i) begin
          unique case (ent_i.cmd)
            CMD_DEPOSIT: state_d = BK_W1;
            CMD_READ, CMD_READ_CLR: state_d = rd_in_range ? BK_RD_WAIT : BK_DONE;
            default: state_d = BK_DONE;
          endcase
        end
      end
      BK_RD_WAIT: state_d = BK_DONE;
      BK_W1: begin
        if (&ok) begin
          state_d = BK_W2;
        end else if (c_q == 3'd7) begin
          state_d = BK_DONE;
        end
      end
      BK_W2: state_d = BK_Q;
      BK_Q: state_d = BK_WR;
      BK_WR: state_d = (c_q == 3'd7) ? BK_DONE : BK_W1;
      BK_DONE: if (slot_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = dep_addr;
    ram_wdata = '0;
    ram_re = 1'b0;
    ram_raddr = dep_addr;
    pop_o = 1'b0;
    unique case (state_q)
      BK_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr_q;
      end
      BK_IDLE: begin
        ram_re = !empty_i && (ent_i.cmd == CMD_READ || ent_i.cmd == CMD_READ_CLR);
        ram_raddr = rd_addr;
      end
      BK_W1: ram_re = &ok;
      BK_WR: begin
        ram_we = 1'b1;
        ram_wdata = sum_sat;
      end
      BK_DONE: begin
        pop_o = slot_free;
        ram_we = slot_free && ent_i.cmd == CMD_READ_CLR && !oor_q;
        ram_waddr = rd_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_CLEAR;
      clr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == BK_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (state_q == BK_DONE && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BK_IDLE: begin
        c_q <= 3'd0;
        val_q <= '0;
        sat_q <= 1'b0;
        oor_q <= (ent_i.cmd == CMD_READ || ent_i.cmd == CMD_READ_CLR) && !rd_in_range;
      end
      BK_RD_WAIT: val_q <= ram_rdata;
      BK_W1: begin
        if (&ok) begin
          w1_q <= p1[FRAC_BITS +: WW];
        end else begin
          oor_q <= 1'b1;
          c_q <= c_q + 3'd1;
        end
      end
      BK_W2: w2_q <= p2[FRAC_BITS +: WW];
      BK_Q: add_q <= p3[FRAC_BITS +: 34];
      BK_WR: begin
        sat_q <= sat_q | sum_ovf;
        c_q <= c_q + 3'd1;
      end
      default: ;
    endcase
    if (state_q == BK_DONE && slot_free) begin
      out_val_q <= val_q;
      out_oor_q <= oor_q;
      out_sat_q <= sat_q;
    end
  end

  tcd_ram #(
    .WIDTH(48),
    .DEPTH(CELLS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_if.valid = out_valid_q;
  assign out_if.cell_value = out_val_q;
  assign out_if.out_of_range = out_oor_q;
  assign out_if.saturated = out_sat_q;
endmodule

@@ hdl/trilinear_charge_deposit_core.sv @@
// Top level of the cloud-in-cell charge deposition core: config registers, front, queue, back.
// Deposit throughput is set by the back end's corner sequencer: each in-grid corner steps through
// W1, W2, Q and WR on the single grid RAM, a skipped corner only through W1, and each beat also
// passes IDLE and DONE. After reset the grid RAM is zeroed, all GRID_DIM^3 cells (4096 by
// default); in ready stays low until then, while configuration writes are taken. Config
// registers reset to origin 0, 1.0.
`timescale 1ns / 1ps
module trilinear_charge_deposit_core #(
  parameter int unsigned GRID_DIM  = 16,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  tcd_in_if.sink      in_if,
  tcd_out_if.source   out_if
);
  import tcd_pkg::*;

  cfg_t cfg_q;
  entry_t push_ent, head_ent;
  q_ctrl_t q_ctrl;
  logic full, empty, clear_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin <= '0;
      for (int a = 0; a < 3; a++) begin
        cfg_q.inv_cell[a] <= 32'(1) << FRAC_BITS;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X: cfg_q.origin[0] <= cfg_data_i;
        REG_ORIGIN_Y: cfg_q.origin[1] <= cfg_data_i;
        REG_ORIGIN_Z: cfg_q.origin[2] <= cfg_data_i;
        REG_INV_X:    cfg_q.inv_cell[0] <= cfg_data_i;
        REG_INV_Y:    cfg_q.inv_cell[1] <= cfg_data_i;
        REG_INV_Z:    cfg_q.inv_cell[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tcd_front #(
    .GRID_DIM (GRID_DIM),
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .clear_busy_i(clear_busy),
    .full_i      (full),
    .push_o      (q_ctrl.push),
    .entry_o     (push_ent),
    .in_if       (in_if)
  );

  tcd_fifo #(
    .DEPTH(2)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (q_ctrl),
    .data_i (push_ent),
    .data_o (head_ent),
    .full_o (full),
    .empty_o(empty)
  );

  tcd_back #(
    .GRID_DIM (GRID_DIM),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ent_i       (head_ent),
    .empty_i     (empty),
    .pop_o       (q_ctrl.pop),
    .clear_busy_o(clear_busy),
    .out_if      (out_if)
  );
endmodule

@@ hdl/tcd_checker.sv @@
// Port-level checks on the deposit core's handshakes and beat accounting, bound to the top.
// Depends on trilinear_charge_deposit_core.
`timescale 1ns / 1ps
module tcd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [47:0] out_value,
  input logic        out_oor,
  input logic        out_sat
);
  logic [3:0] pend_q;
  logic in_acc, out_acc;

  assign in_acc = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 4'(in_acc) - 4'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_oor)
      && $stable(out_sat))
    else $error("result beat changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> pend_q != 4'd0)
    else $error("result beat without an accepted input beat");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 4'd6)
    else $error("too many beats in flight");

  a_reset_quiet: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid && !in_ready)
    else $error("activity right after reset");
endmodule

bind trilinear_charge_deposit_core tcd_checker u_tcd_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_valid (in_if.valid),
  .in_ready (in_if.ready),
  .out_valid(out_if.valid),
  .out_ready(out_if.ready),
  .out_value(out_if.cell_value),
  .out_oor  (out_if.out_of_range),
  .out_sat  (out_if.saturated)
);
